// ===== rtl/bfvt_pkg.sv =====
// Shared types, register codes and widths for the box frustum visibility test.
package bfvt_pkg;

    localparam int COORD_W         = 16;
    localparam int AXES            = 3;
    localparam int PLANE_REGS      = 4;
    localparam int PLANE_COUNT_DEF = 4;
    localparam int PLANE_IDX_W     = $clog2(PLANE_REGS);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Product of a sign-extended normal and a doubled centre or an extent
    localparam int PROD_W  = 2 * (COORD_W + 1);
    // Exact plane test value at doubled scale, with headroom for the sums
    localparam int ACC_W   = PROD_W + 5;
    // Offset d (Q11.4) lifted to the 2^18 scale of the products
    localparam int D_SHIFT = 15;

    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_0     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_3     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CULL_ENABLE = 3'd4;

    // Packed plane: nx in bits 15:0, ny 31:16, nz 47:32, d 63:48
    typedef struct packed {
        logic [COORD_W-1:0]           d;
        logic [AXES-1:0][COORD_W-1:0] n;
    } plane_t;

    typedef struct packed {
        logic [AXES-1:0][COORD_W-1:0] centre;
        logic [AXES-1:0][COORD_W-1:0] extent;
    } box_t;

    typedef struct packed {
        plane_t [PLANE_REGS-1:0] planes;
        logic                    cull_enable;
    } cfg_t;

endpackage

// ===== rtl/bfvt_cfg_regs.sv =====
// Configuration register file: four frustum planes and the cull enable.
module bfvt_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bfvt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bfvt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output bfvt_pkg::cfg_t                   cfg
);
    import bfvt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index) inside
                [REG_PLANE_0:REG_PLANE_3]:
                    cfg_next.planes[cfg_index[PLANE_IDX_W-1:0]] = plane_t'(cfg_data);
                REG_CULL_ENABLE:
                    cfg_next.cull_enable = cfg_data[0];
                default:
                    ; // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.planes      <= '0;
            cfg_reg.cull_enable <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/bfvt_plane_eval.sv =====
// Three-stage farthest-corner test of one box against one plane.
module bfvt_plane_eval (
    input  logic             clk,
    input  bfvt_pkg::plane_t plane,
    input  bfvt_pkg::box_t   box,
    output logic             keep
);
    import bfvt_pkg::*;

    logic signed [PROD_W-1:0] pc_next [AXES];
    logic signed [PROD_W-1:0] pe_next [AXES];
    logic signed [PROD_W-1:0] pc_reg  [AXES];
    logic signed [PROD_W-1:0] pe_reg  [AXES];
    logic signed [ACC_W-1:0]  dterm_next;
    logic signed [ACC_W-1:0]  dterm_reg;
    logic signed [ACC_W-1:0]  sum_next [AXES];
    logic signed [ACC_W-1:0]  sum_reg  [AXES];
    logic signed [ACC_W-1:0]  total_next;
    logic signed [ACC_W-1:0]  total_reg;

    // Stage 1: n_j * 2p_j and |n_j| * s_j per axis
    always_comb
    begin
        logic signed [COORD_W:0] n_w;
        logic signed [COORD_W:0] nabs;
        logic signed [COORD_W:0] ctr2;
        logic signed [COORD_W:0] ext_w;
        n_w   = '0;
        nabs  = '0;
        ctr2  = '0;
        ext_w = '0;
        for (int j = 0; j < AXES; j++)
        begin
            n_w        = $signed({plane.n[j][COORD_W-1], plane.n[j]});
            nabs       = n_w[COORD_W] ? -n_w : n_w;
            ctr2       = $signed({box.centre[j], 1'b0});
            ext_w      = $signed({1'b0, box.extent[j]});
            pc_next[j] = n_w * ctr2;
            pe_next[j] = nabs * ext_w;
        end
        dterm_next = ACC_W'($signed({plane.d, {D_SHIFT{1'b0}}}));
    end

    // Stage 2: fold each axis, offset goes in with the last axis
    always_comb
    begin
        for (int j = 0; j < AXES; j++)
        begin
            sum_next[j] = ACC_W'(pc_reg[j]) + ACC_W'(pe_reg[j])
                        + ((j == AXES - 1) ? dterm_reg : ACC_W'(0));
        end
    end

    // Stage 3: total test value
    always_comb
    begin
        total_next = '0;
        for (int j = 0; j < AXES; j++)
        begin
            total_next = total_next + sum_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        pc_reg    <= pc_next;
        pe_reg    <= pe_next;
        dterm_reg <= dterm_next;
        sum_reg   <= sum_next;
        total_reg <= total_next;
    end

    // Zero counts as inside
    assign keep = ~total_reg[ACC_W-1];

endmodule

// ===== rtl/box_frustum_visibility_test_top.sv =====
// Top level of the box frustum visibility test pipeline.
//
//  channel   direction  handshake                     payload
//  command   in         start, busy (beat: start&~busy) centre_x/y/z, extent_x/y/z
//  result    out        done strobe, one cycle         visible
//  config    in         cfg_valid, cfg_ready           cfg_index, cfg_data
//
// A box enters every cycle; busy stays low. Its result is registered through
// the input register, the three stages of each plane unit (multiply, per-axis
// add, final add) and the output register. Reset clears the valid pipeline
// and loads the plane and cull registers. Results cannot be held off, so the
// pipeline never stalls.
module box_frustum_visibility_test_top #(
    parameter int PLANE_COUNT = bfvt_pkg::PLANE_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [bfvt_pkg::COORD_W-1:0]     centre_x,
    input  logic [bfvt_pkg::COORD_W-1:0]     centre_y,
    input  logic [bfvt_pkg::COORD_W-1:0]     centre_z,
    input  logic [bfvt_pkg::COORD_W-1:0]     extent_x,
    input  logic [bfvt_pkg::COORD_W-1:0]     extent_y,
    input  logic [bfvt_pkg::COORD_W-1:0]     extent_z,
    output logic                             done,
    output logic                             visible,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bfvt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bfvt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bfvt_pkg::*;

    // Planes past the register file are absent and never cull
    localparam int ACTIVE_PLANES = (PLANE_COUNT < PLANE_REGS) ? PLANE_COUNT : PLANE_REGS;
    localparam int STAGES        = 4;

    cfg_t                     cfg;
    box_t                     box_reg;
    box_t                     box_next;
    logic [STAGES-1:0]        vld_reg;
    logic [STAGES-1:0]        vld_next;
    logic [ACTIVE_PLANES-1:0] keep;
    logic                     done_reg;
    logic                     visible_reg;
    logic                     visible_next;

    assign busy = 1'b0;

    bfvt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_comb
    begin
        box_next.centre[0] = centre_x;
        box_next.centre[1] = centre_y;
        box_next.centre[2] = centre_z;
        box_next.extent[0] = extent_x;
        box_next.extent[1] = extent_y;
        box_next.extent[2] = extent_z;
    end

    always_ff @(posedge clk)
    begin
        box_reg <= box_next;
    end

    for (genvar i = 0; i < ACTIVE_PLANES; i++)
    begin : g_plane
        bfvt_plane_eval u_plane (
            .clk   (clk),
            .plane (cfg.planes[i]),
            .box   (box_reg),
            .keep  (keep[i])
        );
    end

    // Advance the valid bits alongside the data stages
    assign vld_next     = {vld_reg[STAGES-2:0], start & ~busy};
    assign visible_next = ~cfg.cull_enable | (&keep);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            done_reg <= vld_reg[STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        visible_reg <= visible_next;
    end

    assign done    = done_reg;
    assign visible = visible_reg;

endmodule
